/* hw/rtl/imdp_pkg.sv */
// Shared types, constants and helper functions for the IMD image stream parser.
package imdp_pkg;

    typedef enum logic [3:0] {
        PH_SIG     = 4'd0,
        PH_COMMENT = 4'd1,
        PH_HDR     = 4'd2,
        PH_SMAP    = 4'd3,
        PH_CMAP    = 4'd4,
        PH_HMAP    = 4'd5,
        PH_CODE    = 4'd6,
        PH_DATA    = 4'd7,
        PH_FILL    = 4'd8,
        PH_HALT    = 4'd9
    } phase_t;

    localparam logic [1:0] KIND_TRACK  = 2'd0;
    localparam logic [1:0] KIND_SECTOR = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [7:0] ERR_SIGNATURE = 8'd0;
    localparam logic [7:0] ERR_MODE      = 8'd1;
    localparam logic [7:0] ERR_GEOMETRY  = 8'd2;
    localparam logic [7:0] ERR_RECORD    = 8'd3;
    localparam logic [7:0] ERR_TRUNCATED = 8'd4;

    localparam logic [7:0] COMMENT_END = 8'h1a;
    localparam logic [7:0] MAX_MODE    = 8'd5;
    localparam logic [7:0] MAX_RECORD  = 8'd8;

    // Result item as it travels from the parser through the queue.
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  cylinder;
        logic [5:0]  head;
        logic [7:0]  sector_id;
        logic        mfm;
        logic [1:0]  rate_code;
        logic [2:0]  size_code;
        logic [1:0]  record_type;
        logic        marked;
        logic [7:0]  value;
        logic [12:0] byte_offset;
        logic        last;
    } result_t;

    // Signature byte at position 0..2 ("IMD").
    function automatic logic [7:0] sig_byte(input logic [1:0] pos);
        logic [7:0] r;
        unique case (pos)
            2'd0:    r = 8'h49;
            2'd1:    r = 8'h4d;
            default: r = 8'h44;
        endcase
        return r;
    endfunction

    // Record type from the record code.
    function automatic logic [1:0] rec_type(input logic [3:0] c);
        logic [1:0] r;
        if (c == 4'd0)
            r = 2'd0;
        else if (c[0])
            r = 2'd1;
        else
            r = 2'd2;
        return r;
    endfunction

endpackage

/* hw/rtl/imd_disk_image_stream_parser.sv */
// IMD disk image byte stream parser, top level.
// Each result is registered in the result queue and shown from its head.
// Throughput: one byte per cycle; the front stalls only when the two-entry
// result queue is full.
// Reset: asynchronous active-low rst_n returns the parser to signature check
// and empties the queue; the sector map holds no reset value.
module imd_disk_image_stream_parser #(
    parameter int MAX_SECTORS   = 256,
    parameter int MAX_SIZE_CODE = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        start_of_file,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  cylinder,
    output logic [5:0]  head,
    output logic [7:0]  sector_id,
    output logic        mfm,
    output logic [1:0]  rate_code,
    output logic [2:0]  size_code,
    output logic [1:0]  record_type,
    output logic        marked,
    output logic [7:0]  value,
    output logic [12:0] byte_offset,
    output logic        last
);

    logic              in_fire;
    logic              res_valid;
    logic              q_full;
    imdp_pkg::result_t res;
    imdp_pkg::result_t q_head;

    assign in_stall = q_full;
    assign in_fire  = in_valid && !q_full;

    imdp_front #(
        .MAX_SECTORS  (MAX_SECTORS),
        .MAX_SIZE_CODE(MAX_SIZE_CODE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .byte_value   (byte_value),
        .start_of_file(start_of_file),
        .end_of_file  (end_of_file),
        .res_valid    (res_valid),
        .res          (res)
    );

    imdp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .push_data(res),
        .full     (q_full),
        .valid    (out_valid),
        .stall    (out_stall),
        .head_data(q_head)
    );

    assign kind        = q_head.kind;
    assign cylinder    = q_head.cylinder;
    assign head        = q_head.head;
    assign sector_id   = q_head.sector_id;
    assign mfm         = q_head.mfm;
    assign rate_code   = q_head.rate_code;
    assign size_code   = q_head.size_code;
    assign record_type = q_head.record_type;
    assign marked      = q_head.marked;
    assign value       = q_head.value;
    assign byte_offset = q_head.byte_offset;
    assign last        = q_head.last;

endmodule

/* hw/rtl/imdp_front.sv */
// Front end: accept bytes, track parse state, build result items.
module imdp_front #(
    parameter int MAX_SECTORS   = 256,
    parameter int MAX_SIZE_CODE = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        byte_value,
    input  logic              start_of_file,
    input  logic              end_of_file,
    output logic              res_valid,
    output imdp_pkg::result_t res
);

    imdp_pkg::phase_t phase_reg, phase_next;
    logic [12:0] count_reg, count_next;
    logic [7:0]  cyl_reg, cyl_next;
    logic [5:0]  head_reg, head_next;
    logic [2:0]  mode_reg, mode_next;
    logic [2:0]  size_reg, size_next;
    logic [8:0]  nsec_reg, nsec_next;
    logic [1:0]  flags_reg, flags_next;
    logic [7:0]  index_reg, index_next;
    logic [3:0]  code_reg, code_next;

    // Sector map, written during the sector map phase, read by the current index
    logic [7:0]  smap_mem [256];
    logic        map_we;
    logic [7:0]  map_id_reg;

    imdp_pkg::phase_t ph;
    logic [12:0] cnt;
    logic [13:0] size_bytes;
    logic        err;
    logic [7:0]  err_code;
    logic [8:0]  idx_inc;

    // Write the map; read the entry that the next sector index selects
    always_ff @(posedge clk)
    begin
        if (map_we)
            smap_mem[count_reg[7:0]] <= byte_value - 8'd1;
        if (map_we && count_reg[7:0] == index_next)
            map_id_reg <= byte_value - 8'd1;
        else
            map_id_reg <= smap_mem[index_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= imdp_pkg::PH_SIG;
            count_reg <= '0;
            cyl_reg   <= '0;
            head_reg  <= '0;
            mode_reg  <= '0;
            size_reg  <= '0;
            nsec_reg  <= '0;
            flags_reg <= '0;
            index_reg <= '0;
            code_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cyl_reg   <= cyl_next;
            head_reg  <= head_next;
            mode_reg  <= mode_next;
            size_reg  <= size_next;
            nsec_reg  <= nsec_next;
            flags_reg <= flags_next;
            index_reg <= index_next;
            code_reg  <= code_next;
        end
    end

    // Decode one byte: next state and result item
    always_comb
    begin
        ph         = start_of_file ? imdp_pkg::PH_SIG : phase_reg;
        cnt        = start_of_file ? 13'd0 : count_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        cyl_next   = start_of_file ? 8'd0 : cyl_reg;
        head_next  = start_of_file ? 6'd0 : head_reg;
        mode_next  = start_of_file ? 3'd0 : mode_reg;
        size_next  = start_of_file ? 3'd0 : size_reg;
        nsec_next  = start_of_file ? 9'd0 : nsec_reg;
        flags_next = start_of_file ? 2'd0 : flags_reg;
        index_next = start_of_file ? 8'd0 : index_reg;
        code_next  = start_of_file ? 4'd0 : code_reg;
        map_we     = 1'b0;
        err        = 1'b0;
        err_code   = imdp_pkg::ERR_SIGNATURE;
        res_valid  = 1'b0;
        res        = '0;
        size_bytes = 14'd128 << size_next;
        idx_inc    = {1'b0, index_next} + 9'd1;

        res.cylinder  = cyl_next;
        res.head      = head_next;
        res.mfm       = (mode_next >= 3'd3);
        res.rate_code = (mode_next >= 3'd3) ? 2'(mode_next - 3'd3) : mode_next[1:0];
        res.size_code = size_next;
        res.sector_id = map_id_reg;

        unique case (ph)
            imdp_pkg::PH_SIG:
            begin
                phase_next = ph;
                if (byte_value != imdp_pkg::sig_byte(cnt[1:0]))
                begin
                    err = 1'b1;
                end
                else if (cnt == 13'd2)
                begin
                    count_next = '0;
                    phase_next = imdp_pkg::PH_COMMENT;
                end
                else
                    count_next = cnt + 13'd1;
            end
            imdp_pkg::PH_COMMENT:
            begin
                phase_next = ph;
                count_next = cnt;
                if (byte_value == imdp_pkg::COMMENT_END)
                begin
                    count_next = '0;
                    phase_next = imdp_pkg::PH_HDR;
                end
            end
            imdp_pkg::PH_HDR:
            begin
                phase_next = ph;
                count_next = cnt + 13'd1;
                priority case (cnt[2:0])
                    3'd0:
                    begin
                        if (byte_value > imdp_pkg::MAX_MODE)
                        begin
                            err      = 1'b1;
                            err_code = imdp_pkg::ERR_MODE;
                        end
                        else
                            mode_next = byte_value[2:0];
                    end
                    3'd1: cyl_next = byte_value;
                    3'd2:
                    begin
                        head_next  = byte_value[5:0];
                        flags_next = byte_value[7:6];
                    end
                    3'd3:
                    begin
                        if ({1'b0, byte_value} > 9'(MAX_SECTORS))
                        begin
                            err      = 1'b1;
                            err_code = imdp_pkg::ERR_GEOMETRY;
                        end
                        else
                            nsec_next = {1'b0, byte_value};
                    end
                    default:
                    begin
                        if (byte_value > 8'(MAX_SIZE_CODE) || byte_value > 8'd6)
                        begin
                            err      = 1'b1;
                            err_code = imdp_pkg::ERR_GEOMETRY;
                        end
                        else
                        begin
                            size_next     = byte_value[2:0];
                            res.kind      = imdp_pkg::KIND_TRACK;
                            res.size_code = byte_value[2:0];
                            res.sector_id = '0;
                            res.value     = nsec_next[7:0];
                            res_valid     = 1'b1;
                            count_next    = '0;
                            phase_next    = (nsec_next == 9'd0) ? imdp_pkg::PH_HDR
                                                                : imdp_pkg::PH_SMAP;
                        end
                    end
                endcase
            end
            imdp_pkg::PH_SMAP, imdp_pkg::PH_CMAP, imdp_pkg::PH_HMAP:
            begin
                phase_next = ph;
                map_we     = (ph == imdp_pkg::PH_SMAP);
                count_next = cnt + 13'd1;
                if ({4'd0, nsec_next} <= cnt + 13'd1)
                begin
                    count_next = '0;
                    if (ph == imdp_pkg::PH_SMAP && flags_next[1])
                        phase_next = imdp_pkg::PH_CMAP;
                    else if (ph != imdp_pkg::PH_HMAP && flags_next[0])
                        phase_next = imdp_pkg::PH_HMAP;
                    else
                    begin
                        index_next = '0;
                        phase_next = imdp_pkg::PH_CODE;
                    end
                end
            end
            imdp_pkg::PH_CODE:
            begin
                phase_next = ph;
                if (byte_value > imdp_pkg::MAX_RECORD)
                begin
                    err      = 1'b1;
                    err_code = imdp_pkg::ERR_RECORD;
                end
                else
                begin
                    code_next       = byte_value[3:0];
                    count_next      = '0;
                    res.kind        = imdp_pkg::KIND_SECTOR;
                    res.record_type = imdp_pkg::rec_type(byte_value[3:0]);
                    res.marked      = (byte_value == 8'd0) || (byte_value >= 8'd5);
                    if (byte_value == 8'd0)
                    begin
                        res_valid  = 1'b1;
                        index_next = idx_inc[7:0];
                        phase_next = ({1'b0, idx_inc[7:0]} >= nsec_next)
                                   ? imdp_pkg::PH_HDR : imdp_pkg::PH_CODE;
                    end
                    else if (byte_value[0])
                    begin
                        res_valid  = 1'b1;
                        phase_next = imdp_pkg::PH_DATA;
                    end
                    else
                        phase_next = imdp_pkg::PH_FILL;
                end
            end
            imdp_pkg::PH_DATA, imdp_pkg::PH_FILL:
            begin
                phase_next      = ph;
                res_valid       = 1'b1;
                res.record_type = imdp_pkg::rec_type(code_next);
                res.marked      = (code_next == 4'd0) || (code_next >= 4'd5);
                res.value       = byte_value;
                if (ph == imdp_pkg::PH_DATA)
                begin
                    res.kind        = imdp_pkg::KIND_DATA;
                    res.byte_offset = cnt;
                    res.last        = ({1'b0, cnt} + 14'd1 >= size_bytes);
                    count_next      = cnt + 13'd1;
                end
                else
                    res.kind = imdp_pkg::KIND_SECTOR;
                if (ph == imdp_pkg::PH_FILL || res.last)
                begin
                    count_next = '0;
                    index_next = idx_inc[7:0];
                    phase_next = ({1'b0, idx_inc[7:0]} >= nsec_next)
                               ? imdp_pkg::PH_HDR : imdp_pkg::PH_CODE;
                end
            end
            default:
            begin
                phase_next = imdp_pkg::PH_HALT;
            end
        endcase

        // End of file: clean only at a track boundary
        if (!err && end_of_file && ph != imdp_pkg::PH_HALT)
        begin
            if (!(phase_next == imdp_pkg::PH_HDR && count_next == 13'd0))
            begin
                err      = 1'b1;
                err_code = imdp_pkg::ERR_TRUNCATED;
            end
            phase_next = imdp_pkg::PH_HALT;
        end
        if (err)
        begin
            res        = '0;
            res.kind   = imdp_pkg::KIND_ERROR;
            res.value  = err_code;
            res_valid  = 1'b1;
            phase_next = imdp_pkg::PH_HALT;
        end

        // Hold everything when no byte is taken
        if (!in_fire)
        begin
            res_valid  = 1'b0;
            map_we     = 1'b0;
            phase_next = phase_reg;
            count_next = count_reg;
            cyl_next   = cyl_reg;
            head_next  = head_reg;
            mode_next  = mode_reg;
            size_next  = size_reg;
            nsec_next  = nsec_reg;
            flags_next = flags_reg;
            index_next = index_reg;
            code_next  = code_reg;
        end
    end

endmodule

/* hw/rtl/imdp_queue.sv */
// Two-entry result queue between the parser and the output port.
module imdp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  imdp_pkg::result_t push_data,
    output logic              full,
    output logic              valid,
    input  logic              stall,
    output imdp_pkg::result_t head_data
);

    imdp_pkg::result_t mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       pop;

    assign pop       = valid && !stall;
    assign valid     = (cnt_reg != 2'd0);
    assign full      = (cnt_reg == 2'd2);
    assign head_data = mem_reg[rptr_reg];

    // Store pushed transaction
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

endmodule

/* hw/rtl/imdp_checker.sv */
// Port-level checker for the IMD parser, bound to the top level.
module imdp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  kind,
    input logic [7:0]  value,
    input logic [12:0] byte_offset,
    input logic        last,
    input logic [7:0]  sector_id
);

    // Hold the value and kind of a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(kind))
        else $error("stalled result changed");

    // Error codes stay in range
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == imdp_pkg::KIND_ERROR |-> value <= imdp_pkg::ERR_TRUNCATED)
        else $error("bad error code");

    // Only data bytes carry an offset or last flag
    a_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != imdp_pkg::KIND_DATA |-> byte_offset == 13'd0 && !last)
        else $error("offset outside data byte");

    // Errors carry the code and no sector id
    a_errz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == imdp_pkg::KIND_ERROR |-> sector_id == 8'd0)
        else $error("error with sector id");

endmodule

bind imd_disk_image_stream_parser imdp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .value      (value),
    .byte_offset(byte_offset),
    .last       (last),
    .sector_id  (sector_id)
);
